// ----- sv/assert_macros.svh -----
// assertion macros used by the frame store controller
// expects clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define LMFS_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

`define LMFS_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define LMFS_ASSERT(label, prop)

`define LMFS_NEVER(label, expr)

`endif

`endif

// ----- sv/lmfs_pkg.sv -----
// shared constants, types and tables of the led matrix frame store
// no dependencies
`default_nettype none

package lmfs_pkg;

    localparam int STORE_BYTES = 32;
    localparam int ADDR_W      = 5;

    localparam logic [1:0] KIND_DRAW = 2'd0;
    localparam logic [1:0] KIND_READ = 2'd1;
    localparam logic [1:0] KIND_FILL = 2'd2;
    localparam logic [1:0] KIND_SCAN = 2'd3;

    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    localparam logic [ADDR_W-1:0] SCAN_LAST = ADDR_W'(STORE_BYTES - 1);

    typedef struct packed {
        logic              pix_op;
        logic [1:0]        kind;
        logic              scan_load;
        logic [ADDR_W-1:0] scan_k;
        logic              scan_last;
    } lmfs_cmd_t;

    typedef struct packed {
        logic out_free;
    } lmfs_sts_t;

    // byte address of the k-th scan beat
    function automatic logic [ADDR_W-1:0] scan_addr(input logic [ADDR_W-1:0] k);
        logic [2:0] ofs;
        begin
            case (k[2:0])
                3'd0:    ofs = 3'd1;
                3'd1:    ofs = 3'd3;
                3'd2:    ofs = 3'd0;
                3'd3:    ofs = 3'd2;
                3'd4:    ofs = 3'd4;
                3'd5:    ofs = 3'd6;
                3'd6:    ofs = 3'd5;
                default: ofs = 3'd7;
            endcase
            scan_addr = {k[ADDR_W-1:3], ofs};
        end
    endfunction

    function automatic logic [7:0] bit_rev(input logic [7:0] b);
        logic [7:0] r;
        begin
            for (int i = 0; i < 8; i++)
            begin
                r[i] = b[7 - i];
            end
            bit_rev = r;
        end
    endfunction

endpackage

`default_nettype wire

// ----- sv/lmfs_ctrl.sv -----
// controller: accepts items and sequences the 32-beat scan
// depends on lmfs_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module lmfs_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         kind,
    input  wire lmfs_pkg::lmfs_sts_t sts,
    output lmfs_pkg::lmfs_cmd_t     cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                        state_reg;
    logic                        state_next;
    logic [lmfs_pkg::ADDR_W-1:0] cnt_reg;
    logic [lmfs_pkg::ADDR_W-1:0] cnt_next;
    logic                        accept;

    assign in_ready = (state_reg == ST_IDLE) && sts.out_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cmd.pix_op    = 1'b0;
        cmd.kind      = kind;
        cmd.scan_load = 1'b0;
        cmd.scan_k    = cnt_reg;
        cmd.scan_last = (cnt_reg == lmfs_pkg::SCAN_LAST);
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (kind == lmfs_pkg::KIND_SCAN)
                    begin
                        state_next = ST_SCAN;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        cmd.pix_op = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (sts.out_free)
                begin
                    cmd.scan_load = 1'b1;
                    cnt_next      = cnt_reg + 1'b1;
                    if (cnt_reg == lmfs_pkg::SCAN_LAST)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    `LMFS_NEVER(a_no_accept_in_scan, state_reg == ST_SCAN && in_ready)
    `LMFS_ASSERT(a_scan_starts, accept && !cmd.pix_op |=> state_reg == ST_SCAN && cnt_reg == '0)
    `LMFS_ASSERT(a_last_ends_scan, cmd.scan_load && cmd.scan_last |=> state_reg == ST_IDLE)
    `LMFS_NEVER(a_one_cmd, cmd.pix_op && cmd.scan_load)

endmodule

`default_nettype wire

// ----- sv/lmfs_datapath.sv -----
// datapath: rotation register, 32-byte frame store, result register
// depends on lmfs_pkg
`default_nettype none

module lmfs_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr_en,
    input  wire logic [1:0]          cfg_wr_data,
    input  wire logic signed [7:0]   x_coord,
    input  wire logic signed [7:0]   y_coord,
    input  wire logic                pixel_on,
    input  wire lmfs_pkg::lmfs_cmd_t cmd,
    output lmfs_pkg::lmfs_sts_t      sts,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     pixel_read,
    output logic [7:0]               shift_bits,
    output logic                     frame_end
);

    logic [1:0]                  rot_reg;
    logic [7:0]                  store_reg [lmfs_pkg::STORE_BYTES];
    logic [7:0]                  store_next [lmfs_pkg::STORE_BYTES];
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        pixel_read_reg;
    logic                        pixel_read_next;
    logic [7:0]                  shift_bits_reg;
    logic [7:0]                  shift_bits_next;
    logic                        frame_end_reg;
    logic                        frame_end_next;
    logic signed [8:0]           xs;
    logic signed [8:0]           ys;
    logic signed [8:0]           u;
    logic signed [8:0]           v;
    logic                        on_panel;
    logic [lmfs_pkg::ADDR_W-1:0] pix_idx;
    logic [2:0]                  pix_bit;
    logic [lmfs_pkg::ADDR_W-1:0] rd_addr;
    logic [7:0]                  rd_byte;

    assign xs = {x_coord[7], x_coord};
    assign ys = {y_coord[7], y_coord};

    // quarter-turn coordinate map
    always_comb
    begin
        case (rot_reg)
            lmfs_pkg::ROT_90:
            begin
                u = 9'sd15 - ys;
                v = xs;
            end
            lmfs_pkg::ROT_180:
            begin
                u = 9'sd15 - xs;
                v = 9'sd15 - ys;
            end
            lmfs_pkg::ROT_270:
            begin
                u = ys;
                v = 9'sd15 - xs;
            end
            default:
            begin
                u = xs;
                v = ys;
            end
        endcase
    end

    assign on_panel = (u[8:4] == 5'd0) && (v[8:4] == 5'd0);
    assign pix_idx  = {v[3:0], u[3]};
    assign pix_bit  = ~u[2:0];

    assign rd_addr = cmd.scan_load ? lmfs_pkg::scan_addr(cmd.scan_k) : pix_idx;
    assign rd_byte = store_reg[rd_addr];

    always_comb
    begin
        for (int i = 0; i < lmfs_pkg::STORE_BYTES; i++)
        begin
            store_next[i] = store_reg[i];
        end
        if (cmd.pix_op && cmd.kind == lmfs_pkg::KIND_FILL)
        begin
            for (int i = 0; i < lmfs_pkg::STORE_BYTES; i++)
            begin
                store_next[i] = {8{pixel_on}};
            end
        end
        else if (cmd.pix_op && cmd.kind == lmfs_pkg::KIND_DRAW && on_panel)
        begin
            store_next[pix_idx][pix_bit] = pixel_on;
        end
    end

    assign sts.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg && !out_ready;
        pixel_read_next = pixel_read_reg;
        shift_bits_next = shift_bits_reg;
        frame_end_next  = frame_end_reg;
        if (cmd.pix_op)
        begin
            out_valid_next  = 1'b1;
            pixel_read_next = (cmd.kind == lmfs_pkg::KIND_READ) && on_panel
                              && rd_byte[pix_bit];
            shift_bits_next = 8'd0;
            frame_end_next  = 1'b1;
        end
        else if (cmd.scan_load)
        begin
            out_valid_next  = 1'b1;
            pixel_read_next = 1'b0;
            // even beats go lsb first
            shift_bits_next = cmd.scan_k[0] ? lmfs_pkg::bit_rev(rd_byte) : rd_byte;
            frame_end_next  = cmd.scan_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg       <= lmfs_pkg::ROT_0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < lmfs_pkg::STORE_BYTES; i++)
            begin
                store_reg[i] <= 8'd0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                rot_reg <= cfg_wr_data;
            end
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < lmfs_pkg::STORE_BYTES; i++)
            begin
                store_reg[i] <= store_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_read_reg <= pixel_read_next;
        shift_bits_reg <= shift_bits_next;
        frame_end_reg  <= frame_end_next;
    end

    assign out_valid  = out_valid_reg;
    assign pixel_read = pixel_read_reg;
    assign shift_bits = shift_bits_reg;
    assign frame_end  = frame_end_reg;

endmodule

`default_nettype wire

// ----- sv/led_matrix_frame_store_scan.sv -----
// 16x16 one-bit led matrix frame store with shift-register scan-out.
// Input channel (in_valid/in_ready) carries kind, x_coord, y_coord and
// pixel_on; output channel (out_valid/out_ready) carries pixel_read,
// shift_bits and frame_end. cfg_wr_en/cfg_wr_data set the rotation.
// Draw, read and fill each give one beat, registered in the cycle after
// acceptance, and the next such item is taken in the following cycle
// when the output register is free or being drained: one item per cycle.
// A scan item gives 32 beats: the controller enters its scan state, then
// each beat is loaded into the output register, one per cycle while the
// output register is free or being drained; the last beat has frame_end
// set. Input stays not ready for the whole scan; the 32-beat sequencer
// counter sets its length. When out_ready is low the result waits in
// the output register and the block takes no new item until it is
// drained. Reset clears the frame store (panel dark), the rotation and
// all control state; the block is ready as soon as reset is released.
// depends on lmfs_pkg, lmfs_ctrl, lmfs_datapath
`default_nettype none

module led_matrix_frame_store_scan (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [1:0]        cfg_wr_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        kind,
    input  wire logic signed [7:0] x_coord,
    input  wire logic signed [7:0] y_coord,
    input  wire logic              pixel_on,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   pixel_read,
    output logic [7:0]             shift_bits,
    output logic                   frame_end
);

    lmfs_pkg::lmfs_cmd_t cmd;
    lmfs_pkg::lmfs_sts_t sts;

    lmfs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .sts      (sts),
        .cmd      (cmd)
    );

    lmfs_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .x_coord     (x_coord),
        .y_coord     (y_coord),
        .pixel_on    (pixel_on),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_read  (pixel_read),
        .shift_bits  (shift_bits),
        .frame_end   (frame_end)
    );

endmodule

`default_nettype wire
